@@ hw/rtl/rlcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rlcf_pkg
// shared constants and command codes of the rgb led cross-fade engine
// ----------------------------------------------------------------------------
package rlcf_pkg;

    localparam int PIXELS_DEF    = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [7:0] LEVEL_MAX   = 8'd255;
    localparam logic [8:0] ELAPSED_MAX = 9'd511;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_HALT  = 2'd3
    } func_t;

endpackage

@@ hw/rtl/rlcf_ram.sv @@
// ----------------------------------------------------------------------------
// rlcf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rlcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/rlcf_div.sv @@
// ----------------------------------------------------------------------------
// rlcf_div
// restoring divider, one quotient bit per cycle, 8-bit divisor
// ----------------------------------------------------------------------------
module rlcf_div #(
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [7:0]    divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   q_reg;
    logic [7:0]      rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [8:0]      trial;
    logic            qbit;

    always_comb
    begin
        trial = {rem_reg, q_reg[DW-1]};
        qbit  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], qbit};
            rem_reg <= qbit ? 8'(trial - {1'b0, divisor}) : trial[7:0];
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/rgb_led_cross_fade_engine_top.sv @@
// ----------------------------------------------------------------------------
// rgb_led_cross_fade_engine_top
// per-pixel linear cross-fade of rgb levels, state held in one ram
// ----------------------------------------------------------------------------
// commands arrive as beats on the s_ channel (command code in s_tuser),
// pixel updates leave as beats on the m_ channel, fade_done in m_tuser and
// m_tlast on the final update caused by one command.
// set color: one read-free ram write, result beat in the cycle after accept;
//   the sequencer stays idle for the next command.
// start fade: ram read, then three parallel serial dividers, one quotient
//   bit per cycle; the next command waits until the entry is written back.
// frame tick: the fading flags are walked one entry per cycle; a fading
//   pixel is read from the ram, then updated and written back with its
//   result beat, which waits while the output slot is not free.
// halt: clears all fading flags, no result.
// the output register holds a beat while m_tready is low; the sequencer
// waits for the slot to free before producing the next result.
// reset clears the fading and written flags; an entry never written reads
// as black with no fade. no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_led_cross_fade_engine_top #(
    parameter int PIXELS    = rlcf_pkg::PIXELS_DEF,
    parameter int FRAC_BITS = rlcf_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel[3:0], red, green, blue, duration, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_pixel[3:0], out_red, out_green, out_blue, pad
    output logic        m_tuser,   // fade_done
    output logic        m_tlast
);

    localparam int AW  = PIXELS > 1 ? $clog2(PIXELS) : 1;
    localparam int CW  = 8 + FRAC_BITS;
    localparam int SW  = 9 + FRAC_BITS;
    localparam int SO  = 3 * CW;
    localparam int TO  = SO + 3 * SW;
    localparam int EO  = TO + 24;
    localparam int LO  = EO + 9;
    localparam int EW  = LO + 8;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_CALC = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]     idx_reg, idx_next;
    logic [PIXELS-1:0] fading_reg, fading_next;
    logic [PIXELS-1:0] written_reg, written_next;
    logic [3:0]        cmd_pixel_reg;
    logic [7:0]        cmd_col_reg [3];
    logic [7:0]        cmd_dur_reg;

    logic              m_valid_reg, m_valid_next;
    logic [27:0]       m_data_reg;
    logic              m_done_reg;
    logic              m_last_reg;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [EW-1:0]     ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [EW-1:0]     ram_rd_data;

    logic [CW-1:0]     rd_cur  [3];
    logic [SW-1:0]     rd_step [3];
    logic [7:0]        rd_tgt  [3];
    logic [8:0]        rd_el;
    logic [7:0]        rd_len;
    logic              rd_written;

    logic [CW:0]       diff    [3];
    logic [CW-1:0]     div_mag [3];
    logic [CW-1:0]     div_q   [3];
    logic              div_done [3];
    logic              div_start;
    logic [SW-1:0]     new_step [3];

    logic [CW-1:0]     tick_cur [3];
    logic [8:0]        el_inc;
    logic              tick_snap;
    logic              higher_fading;

    logic [3:0]        in_pixel;
    logic [7:0]        in_col [3];
    logic [7:0]        in_dur;
    rlcf_pkg::func_t   in_func;
    logic              in_range;
    logic              accept;
    logic              slot_free;
    logic              out_load;
    logic [27:0]       out_data;
    logic              out_done;
    logic              out_last;
    logic              last_idx;

    assign in_func   = rlcf_pkg::func_t'(s_tuser);
    assign in_pixel  = s_tdata[3:0];
    assign in_col[0] = s_tdata[11:4];
    assign in_col[1] = s_tdata[19:12];
    assign in_col[2] = s_tdata[27:20];
    assign in_dur    = s_tdata[35:28];
    assign in_range  = (32'(in_pixel) < PIXELS);

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign last_idx  = (idx_reg == AW'(PIXELS - 1));
    assign div_start = (state_reg == ST_RD);

    // unpack the entry; a never-written pixel reads as black
    always_comb
    begin
        rd_written = written_reg[ram_rd_addr];
        for (int c = 0; c < 3; c++)
        begin
            rd_cur[c]  = rd_written ? ram_rd_data[c*CW +: CW] : '0;
            rd_step[c] = ram_rd_data[SO + c*SW +: SW];
            rd_tgt[c]  = ram_rd_data[TO + c*8 +: 8];
        end
        rd_el  = ram_rd_data[EO +: 9];
        rd_len = ram_rd_data[LO +: 8];
    end

    // step = ((target << frac) - current) / duration, truncated toward zero
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff[c]    = {1'b0, cmd_col_reg[c], FRAC_BITS'(0)} - {1'b0, rd_cur[c]};
            div_mag[c] = diff[c][CW] ? CW'(-diff[c]) : diff[c][CW-1:0];
            if (cmd_dur_reg == 8'd0)
            begin
                new_step[c] = '0;
            end
            else if (diff[c][CW])
            begin
                new_step[c] = -{1'b0, div_q[c]};
            end
            else
            begin
                new_step[c] = {1'b0, div_q[c]};
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        rlcf_div #(
            .DW (CW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_mag[g]),
            .divisor  (cmd_dur_reg),
            .quotient (div_q[g]),
            .done     (div_done[g])
        );
    end

    // tick update of the entry held at the ram output
    always_comb
    begin
        logic [SW:0] sum;
        el_inc    = (rd_el < rlcf_pkg::ELAPSED_MAX) ? rd_el + 9'd1 : rd_el;
        tick_snap = (el_inc > {1'b0, rd_len});
        for (int c = 0; c < 3; c++)
        begin
            sum = {2'b00, rd_cur[c]} + {rd_step[c][SW-1], rd_step[c]};
            if (tick_snap)
            begin
                tick_cur[c] = {rd_tgt[c], FRAC_BITS'(0)};
            end
            else if (sum[SW])
            begin
                tick_cur[c] = '0;
            end
            else if (sum > {2'b00, rlcf_pkg::LEVEL_MAX, FRAC_BITS'(0)})
            begin
                tick_cur[c] = {rlcf_pkg::LEVEL_MAX, FRAC_BITS'(0)};
            end
            else
            begin
                tick_cur[c] = sum[CW-1:0];
            end
        end
        higher_fading = 1'b0;
        for (int j = 0; j < PIXELS; j++)
        begin
            if ((AW + 1)'(j) > {1'b0, idx_reg} && fading_reg[j])
            begin
                higher_fading = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        fading_next  = fading_reg;
        written_next = written_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = idx_reg;
        out_load     = 1'b0;
        out_data     = '0;
        out_done     = 1'b0;
        out_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr = AW'(in_pixel);
                ram_wr_addr = AW'(in_pixel);
                if (accept)
                begin
                    unique case (in_func)
                        rlcf_pkg::FUNC_SET:
                        begin
                            if (in_range)
                            begin
                                for (int c = 0; c < 3; c++)
                                begin
                                    ram_wr_data[c*CW +: CW]  = {in_col[c], FRAC_BITS'(0)};
                                    ram_wr_data[TO + c*8 +: 8] = in_col[c];
                                end
                                ram_wr_en                 = 1'b1;
                                fading_next[AW'(in_pixel)]  = 1'b0;
                                written_next[AW'(in_pixel)] = 1'b1;
                                out_load = 1'b1;
                                out_data = {in_col[2], in_col[1], in_col[0], in_pixel};
                                out_last = 1'b1;
                            end
                        end
                        rlcf_pkg::FUNC_START:
                        begin
                            if (in_range)
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                        rlcf_pkg::FUNC_TICK:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        rlcf_pkg::FUNC_HALT:
                        begin
                            fading_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                ram_rd_addr = AW'(cmd_pixel_reg);
                state_next  = ST_DIV;
            end

            ST_DIV:
            begin
                ram_rd_addr = AW'(cmd_pixel_reg);
                ram_wr_addr = AW'(cmd_pixel_reg);
                if (div_done[0])
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        ram_wr_data[c*CW +: CW]      = rd_cur[c];
                        ram_wr_data[SO + c*SW +: SW] = new_step[c];
                        ram_wr_data[TO + c*8 +: 8]   = cmd_col_reg[c];
                    end
                    ram_wr_data[EO +: 9] = 9'd0;
                    ram_wr_data[LO +: 8] = cmd_dur_reg;
                    ram_wr_en    = 1'b1;
                    fading_next[AW'(cmd_pixel_reg)]  = 1'b1;
                    written_next[AW'(cmd_pixel_reg)] = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (fading_reg[idx_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_CALC;
                end
                else if (last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_CALC:
            begin
                if (slot_free)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        ram_wr_data[c*CW +: CW]      = tick_cur[c];
                        ram_wr_data[SO + c*SW +: SW] = rd_step[c];
                        ram_wr_data[TO + c*8 +: 8]   = rd_tgt[c];
                    end
                    ram_wr_data[EO +: 9] = el_inc;
                    ram_wr_data[LO +: 8] = rd_len;
                    ram_wr_en = 1'b1;
                    if (tick_snap)
                    begin
                        fading_next[idx_reg] = 1'b0;
                    end
                    out_load = 1'b1;
                    out_data = {tick_cur[2][CW-1 -: 8], tick_cur[1][CW-1 -: 8],
                                tick_cur[0][CW-1 -: 8], 4'(idx_reg)};
                    out_done = tick_snap;
                    out_last = !higher_fading;
                    if (last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    rlcf_ram #(
        .WIDTH (EW),
        .DEPTH (PIXELS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            fading_reg  <= '0;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            fading_reg  <= fading_next;
            written_reg <= written_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_pixel_reg <= in_pixel;
            cmd_dur_reg   <= in_dur;
            for (int c = 0; c < 3; c++)
            begin
                cmd_col_reg[c] <= in_col[c];
            end
        end
        if (out_load)
        begin
            m_data_reg <= out_data;
            m_done_reg <= out_done;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};
    assign m_tuser  = m_done_reg;
    assign m_tlast  = m_last_reg;

    // halt leaves no pixel fading
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_func == rlcf_pkg::FUNC_HALT) |=> (fading_reg == '0))
        else $error("fade still armed after halt");

    // an in-range set colour beat shows up on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_func == rlcf_pkg::FUNC_SET && in_range) |=> (m_tvalid && m_tlast))
        else $error("set colour result missing");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (state_reg == ST_DIV))
        else $error("divider done outside divide wait");

    // a fade-start arms the pixel it was issued for
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done[0]) |=> fading_reg[AW'($past(cmd_pixel_reg))])
        else $error("started fade not armed");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb led cross-fade engine: commands go in as
// bursts from a queue, every pixel update is checked against a local model
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NPIX = 16;
    localparam int FB   = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        rlcf_pkg::func_t func;
        logic [3:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] duration;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
        logic       last;
    } upd_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    rgb_led_cross_fade_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // fade model state
    logic [23:0] level_q   [NPIX*3];
    logic signed [24:0] step_q [NPIX*3];
    logic [7:0]  target_q  [NPIX*3];
    logic [8:0]  frames_q  [NPIX];
    logic [7:0]  length_q  [NPIX];
    logic        fading_q  [NPIX];

    cmd_t pending_cmds[$];
    upd_t expected_updates[$];
    int   errors = 0;
    int   n_updates = 0;
    int   n_done = 0;
    int   n_cmds = 0;
    int   idle_cycles = 0;
    bit   stim_done = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic upd_t pixel_update(int p, bit done);
        upd_t u;
        u.pixel = p[3:0];
        u.red   = level_q[p*3][23:16];
        u.green = level_q[p*3+1][23:16];
        u.blue  = level_q[p*3+2][23:16];
        u.done  = done;
        u.last  = 0;
        return u;
    endfunction

    task automatic apply_command(cmd_t c);
        logic [7:0] col [3];
        longint diff, v;
        int n;
        upd_t u;
        col[0] = c.red; col[1] = c.green; col[2] = c.blue;
        n = 0;
        case (c.func)
            rlcf_pkg::FUNC_SET:
            begin
                fading_q[c.pixel] = 0;
                for (int k = 0; k < 3; k++)
                begin
                    level_q[c.pixel*3+k]  = {col[k], 16'h0};
                    target_q[c.pixel*3+k] = col[k];
                end
                u = pixel_update(c.pixel, 0);
                u.last = 1;
                expected_updates.push_back(u);
            end
            rlcf_pkg::FUNC_START:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    diff = longint'({col[k], 16'h0}) - longint'(level_q[c.pixel*3+k]);
                    step_q[c.pixel*3+k] = (c.duration == 0) ? 25'sd0
                                        : 25'(diff / longint'(c.duration));
                    target_q[c.pixel*3+k] = col[k];
                end
                frames_q[c.pixel] = 0;
                length_q[c.pixel] = c.duration;
                fading_q[c.pixel] = 1;
            end
            rlcf_pkg::FUNC_HALT:
                for (int p = 0; p < NPIX; p++) fading_q[p] = 0;
            default:
            begin
                for (int p = 0; p < NPIX; p++)
                begin
                    bit done;
                    if (fading_q[p])
                    begin
                        done = 0;
                        if (frames_q[p] < rlcf_pkg::ELAPSED_MAX) frames_q[p]++;
                        if (frames_q[p] <= {1'b0, length_q[p]})
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                v = longint'(level_q[p*3+k]) + longint'(step_q[p*3+k]);
                                if (v > (longint'(rlcf_pkg::LEVEL_MAX) << FB))
                                    v = longint'(rlcf_pkg::LEVEL_MAX) << FB;
                                if (v < 0) v = 0;
                                level_q[p*3+k] = v[23:0];
                            end
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                                level_q[p*3+k] = {target_q[p*3+k], 16'h0};
                            fading_q[p] = 0;
                            done = 1;
                        end
                        expected_updates.push_back(pixel_update(p, done));
                        n++;
                    end
                end
                if (n > 0) expected_updates[$].last = 1;
            end
        endcase
    endtask

    function automatic cmd_t make_cmd(rlcf_pkg::func_t f, int p, int r, int g, int b, int d);
        cmd_t c;
        c.func = f; c.pixel = p[3:0]; c.red = r[7:0]; c.green = g[7:0];
        c.blue = b[7:0]; c.duration = d[7:0];
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        int r;
        int d;
        r = $urandom_range(99);
        // mostly short fades so that ticks see them finish
        d = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
        if (r < 15)
            return make_cmd(rlcf_pkg::FUNC_SET, $urandom_range(15), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (r < 45)
            return make_cmd(rlcf_pkg::FUNC_START, $urandom_range(15), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255), d);
        else if (r < 97)
            return make_cmd(rlcf_pkg::FUNC_TICK, $urandom_range(15), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255), $urandom_range(255));
        return make_cmd(rlcf_pkg::FUNC_HALT, $urandom_range(15), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255));
    endfunction

    initial
    begin
        for (int p = 0; p < NPIX*3; p++)
        begin
            level_q[p] = 0; step_q[p] = 0; target_q[p] = 0;
        end
        for (int p = 0; p < NPIX; p++)
        begin
            frames_q[p] = 0; length_q[p] = 0; fading_q[p] = 0;
        end
        // directed part
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_SET, 0, 255, 255, 255, 255));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_SET, 15, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 0, 0, 128, 255, 3));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 15, 255, 1, 170, 255));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 7, 200, 100, 50, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        // restart mid fade
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 0, 255, 0, 0, 2));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        // cancels fade
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_SET, 15, 10, 20, 30, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_HALT, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 3, 255, 255, 255, 1));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_START, 4, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
        for (int k = 0; k < 350; k++)
            pending_cmds.push_back(random_cmd());
        // drain any fades left running
        for (int k = 0; k < 3; k++)
            pending_cmds.push_back(make_cmd(rlcf_pkg::FUNC_HALT, 0, 0, 0, 0, 0));
        stim_done = 1;
    end

    // sender: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= rlcf_pkg::FUNC_SET;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(pending_cmds.pop_front());
                n_cmds++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    s_tvalid <= 1;
                    s_tuser  <= pending_cmds[0].func;
                    s_tdata  <= {8'h0, pending_cmds[0].duration, pending_cmds[0].blue,
                                 pending_cmds[0].green, pending_cmds[0].red,
                                 pending_cmds[0].pixel};
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(12);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
                    end
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // receiver stall pattern and checker
    int stall_phase = 0;
    always @(posedge clk or negedge rst_n)
    begin
        upd_t want;
        upd_t got;
        if (!rst_n)
        begin
            m_tready <= 0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 64;
            m_tready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(2) != 0);
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[3:0], m_tdata[11:4], m_tdata[19:12], m_tdata[27:20],
                       m_tuser, m_tlast};
                n_updates++;
                if (m_tuser) n_done++;
                if (expected_updates.size() == 0)
                begin
                    $display("%0t: unexpected pixel update expected none actual %p",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: update mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        wait (stim_done);
        while (pending_cmds.size() > 0 || expected_updates.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (expected_updates.size() > 0)
        begin
            $display("%0d pixel updates never arrived", expected_updates.size());
            errors++;
        end
        $display("run: %0d commands, %0d pixel updates (%0d fade ends), %0d errors",
                 n_cmds, n_updates, n_done, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/rlcf_pkg.sv
hw/rtl/rlcf_ram.sv
hw/rtl/rlcf_div.sv
hw/rtl/rgb_led_cross_fade_engine_top.sv
tb/tb_top.sv
